// File: rtl/core/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// lbpc_pkg: shared types and constants for the lamp blink/pulse controller
// Holds the command and result word layouts, opcodes and default sizes.
// ----------------------------------------------------------------------------
package lbpc_pkg;

  localparam int LAMP_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF  = 16;

  localparam logic [15:0] STEP_TICKS_RESET = 16'd300;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_PULSE = 3'd2;
  localparam logic [2:0] OP_BLINK = 3'd3;
  localparam logic [2:0] OP_TEST  = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  led_index;
    logic        level;
    logic [15:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [3:0] led_levels;
    logic       self_test_busy;
  } out_word_t;

endpackage

// File: rtl/core/led_blink_pulse_controller.sv
// ----------------------------------------------------------------------------
// led_blink_pulse_controller: steady, pulse and blink lamp driver
// A tick sweeps every lamp through the single lamp update unit, one lamp a
// cycle, then runs the self-test step; any other command is carried out in
// the execute state. Both end in the finish state, which registers the result.
// busy stays high until the finish state is left, so a new command waits.
// Reset (rst_n low, synchronous) darkens all lamps and stops the self-test.
// The receiver cannot stall; each result word is shown for one cycle.
// ----------------------------------------------------------------------------
module led_blink_pulse_controller #(
  parameter int LAMP_COUNT = lbpc_pkg::LAMP_COUNT_DEF,
  parameter int TIME_BITS  = lbpc_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel: a word is taken when start is high and busy is low.
  input  logic                start,
  output logic                busy,
  input  lbpc_pkg::in_word_t  in_data,
  // Result channel: one word per command, valid for a single cycle.
  output logic                out_valid,
  output lbpc_pkg::out_word_t out_data,
  // Self-test step length register.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int LIDX_W = (LAMP_COUNT > 1) ? $clog2(LAMP_COUNT) : 1;
  localparam int POS_W  = $clog2(LAMP_COUNT + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_LAMP = 3'd2;
  localparam logic [2:0] ST_TEST = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Captured command word. The duration is saturated to the time width
  // when the word is taken.
  lbpc_pkg::in_word_t   cmd_r;
  logic [TIME_BITS-1:0] cmd_dur_r;
  logic [31:0]          dur_wide;
  logic [TIME_BITS-1:0] dur_sat;

  // Per-lamp state.
  logic [LAMP_COUNT-1:0] lit_r;
  logic [TIME_BITS-1:0]  per_r [LAMP_COUNT];
  logic [TIME_BITS-1:0]  ela_r [LAMP_COUNT];
  logic [TIME_BITS-1:0]  pul_r [LAMP_COUNT];

  // Self-test state and its step length.
  logic             test_act_r, test_act_nxt;
  logic [POS_W-1:0] test_pos_r, test_pos_nxt;
  logic [15:0]      test_ela_r, test_ela_nxt;
  logic [15:0]      step_r;
  logic [15:0]      test_inc;

  // Lamp sweep counter for ticks.
  logic [LIDX_W-1:0] lamp_r, lamp_nxt;

  // Shared lamp update unit: one read port, one write-back.
  logic [LIDX_W-1:0]    rd_idx;
  logic                 r_lit;
  logic [TIME_BITS-1:0] r_per, r_ela, r_pul;
  logic                 u_wr;
  logic                 u_lit;
  logic [TIME_BITS-1:0] u_per, u_ela, u_pul;
  logic [TIME_BITS-1:0] ela_inc;
  logic                 idx_ok;
  logic                 clr_all;
  logic                 t_off_en, t_on_en;

  // Result register.
  logic                  out_valid_r;
  lbpc_pkg::out_word_t   out_data_r;
  logic [LAMP_COUNT+3:0] lit_pad;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Durations longer than the time width clamp at its maximum.
  assign dur_wide = 32'(in_data.duration_ms);
  assign dur_sat  = (dur_wide > 32'(TIME_MAX)) ? TIME_MAX : dur_wide[TIME_BITS-1:0];

  assign idx_ok = (32'(cmd_r.led_index) < 32'(LAMP_COUNT));

  // The unit reads the swept lamp on a tick and the addressed lamp otherwise.
  assign rd_idx  = (state_r == ST_LAMP) ? lamp_r : LIDX_W'(cmd_r.led_index);
  assign r_lit   = lit_r[rd_idx];
  assign r_per   = per_r[rd_idx];
  assign r_ela   = ela_r[rd_idx];
  assign r_pul   = pul_r[rd_idx];
  assign ela_inc = r_ela + 1'b1;

  always_comb begin
    u_wr    = 1'b0;
    u_lit   = r_lit;
    u_per   = r_per;
    u_ela   = r_ela;
    u_pul   = r_pul;
    clr_all = 1'b0;
    if (state_r == ST_LAMP) begin
      u_wr = 1'b1;
      if (r_pul != '0) begin
        // A pulse counts down; blink waits until the pulse is over.
        u_pul = r_pul - 1'b1;
        if (r_pul == TIME_BITS'(1)) begin
          u_lit = 1'b0;
        end
      end else if (r_per != '0) begin
        // Toggle once the phase reaches half the period.
        if (ela_inc >= (r_per >> 1)) begin
          u_ela = '0;
          u_lit = ~r_lit;
        end else begin
          u_ela = ela_inc;
        end
      end
    end else if (state_r == ST_EXEC) begin
      unique case (cmd_r.opcode)
        lbpc_pkg::OP_SET: begin
          u_wr  = idx_ok;
          u_per = '0;
          u_pul = '0;
          u_lit = cmd_r.level;
        end
        lbpc_pkg::OP_PULSE: begin
          u_wr  = idx_ok && (cmd_dur_r != '0);
          u_per = '0;
          u_pul = cmd_dur_r;
          u_lit = 1'b1;
        end
        lbpc_pkg::OP_BLINK: begin
          u_wr  = idx_ok && (cmd_dur_r != '0);
          u_per = cmd_dur_r;
          u_ela = '0;
        end
        lbpc_pkg::OP_TEST: begin
          clr_all = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Self-test step, run once after the lamps on every tick.
  assign test_inc = test_ela_r + 1'b1;

  always_comb begin
    test_act_nxt = test_act_r;
    test_pos_nxt = test_pos_r;
    test_ela_nxt = test_ela_r;
    t_off_en     = 1'b0;
    t_on_en      = 1'b0;
    if (clr_all) begin
      test_act_nxt = 1'b1;
      test_pos_nxt = '0;
      test_ela_nxt = '0;
    end else if ((state_r == ST_TEST) && test_act_r) begin
      if (test_inc < step_r) begin
        test_ela_nxt = test_inc;
      end else begin
        test_ela_nxt = '0;
        // The lamp shown so far goes dark and the next one, if any, lights.
        t_off_en = (test_pos_r != '0);
        if (32'(test_pos_r) >= 32'(LAMP_COUNT)) begin
          test_act_nxt = 1'b0;
          test_pos_nxt = '0;
        end else begin
          t_on_en      = 1'b1;
          test_pos_nxt = test_pos_r + 1'b1;
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    lamp_nxt  = lamp_r;
    unique case (state_r)
      ST_IDLE: begin
        lamp_nxt = '0;
        if (start) begin
          state_nxt = (in_data.opcode == lbpc_pkg::OP_TICK) ? ST_LAMP : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
      end
      ST_LAMP: begin
        if (lamp_r == LIDX_W'(LAMP_COUNT - 1)) begin
          state_nxt = ST_TEST;
        end else begin
          lamp_nxt = lamp_r + 1'b1;
        end
      end
      ST_TEST: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lamp_r      <= '0;
      test_act_r  <= 1'b0;
      test_pos_r  <= '0;
      test_ela_r  <= '0;
      step_r      <= lbpc_pkg::STEP_TICKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lamp_r      <= lamp_nxt;
      test_act_r  <= test_act_nxt;
      test_pos_r  <= test_pos_nxt;
      test_ela_r  <= test_ela_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_data;
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r     <= in_data;
      cmd_dur_r <= dur_sat;
    end
  end

  // Lamp state write-back. Writes from the unit and from the self-test
  // happen in different sequencer states, so they never collide.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= '0;
      for (int i = 0; i < LAMP_COUNT; i++) begin
        per_r[i] <= '0;
        ela_r[i] <= '0;
        pul_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LAMP_COUNT; i++) begin
        if (clr_all) begin
          lit_r[i] <= 1'b0;
          per_r[i] <= '0;
          pul_r[i] <= '0;
        end else if (u_wr && (rd_idx == LIDX_W'(i))) begin
          lit_r[i] <= u_lit;
          per_r[i] <= u_per;
          ela_r[i] <= u_ela;
          pul_r[i] <= u_pul;
        end else if (t_off_en && ((32'(test_pos_r) - 32'd1) == 32'(i))) begin
          lit_r[i] <= 1'b0;
          per_r[i] <= '0;
          pul_r[i] <= '0;
        end else if (t_on_en && (32'(test_pos_r) == 32'(i))) begin
          lit_r[i] <= 1'b1;
          per_r[i] <= '0;
          pul_r[i] <= '0;
        end
      end
    end
  end

  // Result word. Only the first four lamps are reported.
  assign lit_pad = {4'b0000, lit_r};

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_data_r.led_levels     <= lit_pad[3:0];
      out_data_r.self_test_busy <= test_act_r;
    end
  end

  // A result word appears only right after the sequencer finishes an item.
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DONE))
    else $error("result strobe without a finished item");

  // A command other than a tick gives its result after the execute and finish states.
  a_cmd_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.opcode != lbpc_pkg::OP_TICK)) |-> ##3 out_valid)
    else $error("command result missing");

  // A tick gives its result after the lamp sweep and the self-test step.
  a_tick_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.opcode == lbpc_pkg::OP_TICK))
      |-> ##(LAMP_COUNT + 3) out_valid)
    else $error("tick result missing");

  // The self-test position never runs past the lamp count.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(test_pos_r) <= 32'(LAMP_COUNT))
    else $error("self-test position out of range");

  // An idle self-test always sits at its first position.
  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !test_act_r |-> (test_pos_r == '0))
    else $error("self-test position not cleared");

endmodule
